/* hw/rtl/pwg_pkg.sv */
// Shared types, constants and the sine table of the periodic waveform generator.
`default_nettype none
package pwg_pkg;

	localparam int OP_W    = 3;
	localparam int PH_W    = 16;
	localparam int MAG_W   = 16;
	localparam int PER_W   = 16;
	localparam int MFS_W   = 15;
	localparam int SFS_W   = 16;
	localparam int CIDX_W  = 2;
	localparam int CDAT_W  = 16;
	localparam int DIV_NW  = 34;
	localparam int DIV_DW  = 16;
	localparam int WAVE_W  = 36;
	localparam int ANG_W   = 25;
	localparam int LUT_W   = 15;

	localparam logic [OP_W-1:0] OP_SINE   = 3'd0;
	localparam logic [OP_W-1:0] OP_SQUARE = 3'd1;
	localparam logic [OP_W-1:0] OP_TRI    = 3'd2;
	localparam logic [OP_W-1:0] OP_SAW_UP = 3'd3;
	localparam logic [OP_W-1:0] OP_SAW_DN = 3'd4;

	localparam logic [CIDX_W-1:0] CFG_PERIOD = 2'd0;
	localparam logic [CIDX_W-1:0] CFG_MFS    = 2'd1;
	localparam logic [CIDX_W-1:0] CFG_SFS    = 2'd2;

	localparam logic [PER_W-1:0] PERIOD_RST = 16'd1000;
	localparam logic [MFS_W-1:0] MFS_RST    = 15'd10000;
	localparam logic [SFS_W-1:0] SFS_RST    = 16'd10000;

	localparam logic [ANG_W-1:0] RECIP_360 = 25'd23860930;

	typedef struct packed {
		logic [OP_W-1:0]          op;
		logic [PH_W-1:0]          ph;
		logic signed [MAG_W-1:0]  mag;
		logic signed [WAVE_W-1:0] wave;
		logic                     big;
	} side_t;

	function automatic logic signed [LUT_W-1:0] sine_lut(input logic [5:0] idx);
		logic signed [LUT_W-1:0] v;
		case (idx)
			6'd0: v = 15'sd0;
			6'd1: v = 15'sd1736;
			6'd2: v = 15'sd3420;
			6'd3: v = 15'sd5000;
			6'd4: v = 15'sd6428;
			6'd5: v = 15'sd7660;
			6'd6: v = 15'sd8660;
			6'd7: v = 15'sd9397;
			6'd8: v = 15'sd9848;
			6'd9: v = 15'sd10000;
			6'd10: v = 15'sd9848;
			6'd11: v = 15'sd9397;
			6'd12: v = 15'sd8660;
			6'd13: v = 15'sd7660;
			6'd14: v = 15'sd6428;
			6'd15: v = 15'sd5000;
			6'd16: v = 15'sd3420;
			6'd17: v = 15'sd1736;
			6'd18: v = 15'sd0;
			6'd19: v = -15'sd1736;
			6'd20: v = -15'sd3420;
			6'd21: v = -15'sd5000;
			6'd22: v = -15'sd6428;
			6'd23: v = -15'sd7660;
			6'd24: v = -15'sd8660;
			6'd25: v = -15'sd9397;
			6'd26: v = -15'sd9848;
			6'd27: v = -15'sd10000;
			6'd28: v = -15'sd9848;
			6'd29: v = -15'sd9397;
			6'd30: v = -15'sd8660;
			6'd31: v = -15'sd7660;
			6'd32: v = -15'sd6428;
			6'd33: v = -15'sd5000;
			6'd34: v = -15'sd3420;
			6'd35: v = -15'sd1736;
			default: v = 15'sd0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

/* hw/rtl/pwg_div.sv */
// Pipelined restoring divider, one quotient bit per stage, with sideband.
`default_nettype none
module pwg_div
	import pwg_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              in_vld,
	input  wire logic [DIV_NW-1:0] num,
	input  wire logic              neg_in,
	input  wire logic [DIV_DW-1:0] den,
	input  wire side_t             side_in,
	output logic                   out_vld,
	output logic [DIV_NW-1:0]      quot,
	output logic                   neg_out,
	output side_t                  side_out
);

	logic [DIV_NW-1:0] work_s [1:DIV_NW];
	logic [DIV_DW-1:0] rem_s  [1:DIV_NW];
	logic              vld_s  [1:DIV_NW];
	logic              neg_s  [1:DIV_NW];
	side_t             side_s [1:DIV_NW];

	for (genvar k = 0; k < DIV_NW; k++) begin : g_step
		logic [DIV_NW-1:0] w_in;
		logic [DIV_DW-1:0] r_in;
		logic              v_in;
		logic              n_in;
		side_t             sd_in;
		logic [DIV_DW:0]   trial;
		logic [DIV_DW:0]   diff;
		logic              take;

		if (k == 0) begin : g_first
			assign w_in  = num;
			assign r_in  = '0;
			assign v_in  = in_vld;
			assign n_in  = neg_in;
			assign sd_in = side_in;
		end else begin : g_next
			assign w_in  = work_s[k];
			assign r_in  = rem_s[k];
			assign v_in  = vld_s[k];
			assign n_in  = neg_s[k];
			assign sd_in = side_s[k];
		end

		assign trial = {r_in, w_in[DIV_NW-1]};
		assign diff  = trial - {1'b0, den};
		assign take  = trial >= {1'b0, den};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				work_s[k+1] <= {w_in[DIV_NW-2:0], take};
				rem_s[k+1]  <= take ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
				neg_s[k+1]  <= n_in;
				side_s[k+1] <= sd_in;
			end
		end
	end

	assign out_vld  = vld_s[DIV_NW];
	assign quot     = (den == '0) ? '0 : work_s[DIV_NW];
	assign neg_out  = neg_s[DIV_NW];
	assign side_out = side_s[DIV_NW];

endmodule
`default_nettype wire

/* hw/rtl/pwg_front.sv */
// Input stages: triangle fold and the numerator of the division by the period.
`default_nettype none
module pwg_front
	import pwg_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    en,
	input  wire logic                    in_vld,
	input  wire logic [OP_W-1:0]         op,
	input  wire logic [PH_W-1:0]         ph,
	input  wire logic signed [MAG_W-1:0] mag,
	input  wire logic [PER_W-1:0]        per,
	input  wire logic [MFS_W-1:0]        mfs,
	output logic                         out_vld,
	output logic [DIV_NW-1:0]            num,
	output logic                         neg,
	output side_t                        side
);

	logic [PER_W:0]           half_p1;
	logic                     ph_le;
	logic                     pneg;
	logic [PH_W-1:0]          pabs;

	logic                     vld_s1;
	logic [OP_W-1:0]          op_s1;
	logic [PH_W-1:0]          ph_s1;
	logic signed [MAG_W-1:0]  mag_s1;
	logic [PH_W-1:0]          pabs_s1;
	logic                     pneg_s1;

	logic [DIV_NW-1:0]        num_c;
	logic                     neg_c;

	logic                     vld_s2;
	logic [DIV_NW-1:0]        num_s2;
	logic                     neg_s2;
	side_t                    side_s2;

	assign half_p1 = {2'b0, per[PER_W-1:1]} + (PER_W+1)'(1);
	assign ph_le   = {1'b0, ph} <= half_p1;
	assign pneg    = !ph_le && (ph > per);
	assign pabs    = ph_le ? ph : (pneg ? ph - per : per - ph);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
		end
	end

	always_comb begin
		num_c = '0;
		neg_c = 1'b0;
		case (op_s1)
			OP_SINE: begin
				num_c = DIV_NW'(ph_s1) * DIV_NW'(360);
			end
			OP_TRI: begin
				num_c = (DIV_NW'(pabs_s1) * DIV_NW'(mfs)) << 2;
				neg_c = pneg_s1;
			end
			OP_SAW_UP, OP_SAW_DN: begin
				num_c = (DIV_NW'(ph_s1) * DIV_NW'(mfs)) << 1;
			end
			default: begin
				num_c = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1        <= op;
			ph_s1        <= ph;
			mag_s1       <= mag;
			pabs_s1      <= pabs;
			pneg_s1      <= pneg;
			num_s2       <= num_c;
			neg_s2       <= neg_c;
			side_s2.op   <= op_s1;
			side_s2.ph   <= ph_s1;
			side_s2.mag  <= mag_s1;
			side_s2.wave <= '0;
			side_s2.big  <= 1'b0;
		end
	end

	assign out_vld = vld_s2;
	assign num     = num_s2;
	assign neg     = neg_s2;
	assign side    = side_s2;

endmodule
`default_nettype wire

/* hw/rtl/pwg_sine.sv */
// Sine stages: angle wrap, table lookup with interpolation, scaling numerator.
`default_nettype none
module pwg_sine
	import pwg_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             en,
	input  wire logic             in_vld,
	input  wire logic [ANG_W-1:0] ang,
	input  wire side_t            side_in,
	input  wire logic [MFS_W-1:0] mfs,
	output logic                  out_vld,
	output logic [DIV_NW-1:0]     num,
	output logic                  neg,
	output side_t                 side_out
);

	localparam int PROD_W = 2 * ANG_W;
	localparam int Q_W    = 17;

	logic [PROD_W-1:0]        rprod;
	logic [ANG_W-1:0]         rem360;
	logic [16:0]              t205;
	logic [5:0]               idx;
	logic [8:0]               fr9;
	logic signed [LUT_W-1:0]  lo;
	logic signed [LUT_W-1:0]  hi;
	logic [14:0]              tabs;
	logic [30:0]              q10p;
	logic [10:0]              q10;
	logic [14:0]              sabs;

	logic                     vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	side_t                    side_s1, side_s2, side_s3, side_s4, side_s5, side_s6;
	logic [ANG_W-1:0]         ang_s1;
	logic [Q_W-1:0]           q360_s1;
	logic [8:0]               a_s2;
	logic signed [LUT_W-1:0]  lo_s3, lo_s4;
	logic signed [15:0]       d_s3;
	logic [3:0]               frac_s3;
	logic signed [15:0]       t_s4;
	logic signed [15:0]       s_s5;
	logic [DIV_NW-1:0]        num_s6;
	logic                     neg_s6;

	assign rprod  = PROD_W'(ang) * PROD_W'(RECIP_360);
	assign rem360 = ang_s1 - ANG_W'(q360_s1) * ANG_W'(360);
	assign t205   = 17'(a_s2) * 17'd205;
	assign idx    = t205[16:11];
	assign fr9    = a_s2 - 9'(idx) * 9'd10;
	assign lo     = sine_lut(idx);
	assign hi     = sine_lut(idx + 6'd1);
	assign tabs   = t_s4[15] ? 15'(-t_s4) : 15'(t_s4);
	assign q10p   = 31'(tabs) * 31'd52429;
	assign q10    = q10p[29:19];
	assign sabs   = s_s5[15] ? 15'(-s_s5) : 15'(s_s5);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= side_in;
			side_s2 <= side_s1;
			side_s3 <= side_s2;
			side_s4 <= side_s3;
			side_s5 <= side_s4;
			side_s6 <= side_s5;
			ang_s1  <= ang;
			q360_s1 <= rprod[PROD_W-1:33];
			a_s2    <= rem360[8:0];
			lo_s3   <= lo;
			d_s3    <= 16'(hi) - 16'(lo);
			frac_s3 <= fr9[3:0];
			lo_s4   <= lo_s3;
			t_s4    <= 16'(d_s3 * $signed({1'b0, frac_s3}));
			s_s5    <= t_s4[15] ? 16'(lo_s4) - 16'(q10) : 16'(lo_s4) + 16'(q10);
			num_s6  <= DIV_NW'(sabs) * DIV_NW'(mfs);
			neg_s6  <= s_s5[15];
		end
	end

	assign out_vld  = vld_s6;
	assign num      = num_s6;
	assign neg      = neg_s6;
	assign side_out = side_s6;

endmodule
`default_nettype wire

/* hw/rtl/periodic_waveform_generator.sv */
// Top level of the periodic waveform generator: registers, pipeline and output stage.
//
//  channel   direction  handshake               payload
//  in        input      in_valid / in_stall     operation, phase, magnitude
//  out       output     out_valid / out_stall   sample, saturated
//  cfg       input      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One item enters per cycle while the output is not stalled. The pipeline is made
// of three 34-stage dividers (by period, sine scale and magnitude scale), one
// quotient bit per stage, plus the input, sine, product and output stages.
// Reset clears all valid bits and loads the default register values.
// A stalled output freezes the whole pipeline, which then stalls the input.
`default_nettype none
module periodic_waveform_generator
	import pwg_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_stall,
	input  wire logic [OP_W-1:0]         operation,
	input  wire logic [PH_W-1:0]         phase,
	input  wire logic signed [MAG_W-1:0] magnitude,
	output logic                         out_valid,
	input  wire logic                    out_stall,
	output logic signed [15:0]           sample,
	output logic                         saturated,
	input  wire logic                    cfg_valid,
	output logic                         cfg_ready,
	input  wire logic [CIDX_W-1:0]       cfg_index,
	input  wire logic [CDAT_W-1:0]       cfg_data
);

	logic [PER_W-1:0]         per_q;
	logic [MFS_W-1:0]         mfs_q;
	logic [SFS_W-1:0]         sfs_q;
	logic                     en;

	logic                     fr_vld;
	logic [DIV_NW-1:0]        fr_num;
	logic                     fr_neg;
	side_t                    fr_side;

	logic                     d1_vld;
	logic [DIV_NW-1:0]        d1_q;
	logic                     d1_neg;
	side_t                    d1_side;

	logic [PER_W:0]           half_p1;
	logic signed [WAVE_W-1:0] q1s;
	logic signed [WAVE_W-1:0] mfs_w;
	logic signed [WAVE_W-1:0] wave_c;
	side_t                    side_c1;

	logic                     vld_s1;
	side_t                    side_s1;
	logic [ANG_W-1:0]         ang_s1;

	logic                     sn_vld;
	logic [DIV_NW-1:0]        sn_num;
	logic                     sn_neg;
	side_t                    sn_side;

	logic                     d2_vld;
	logic [DIV_NW-1:0]        d2_q;
	logic                     d2_neg;
	side_t                    d2_side;

	logic signed [WAVE_W-1:0] q2s;
	side_t                    side_c2;
	side_t                    side_c4;
	logic                     vld_s2, vld_s3, vld_s4;
	side_t                    side_s2, side_s3, side_s4;
	logic signed [51:0]       p_s3;
	logic [50:0]              pabs;
	logic [DIV_NW-1:0]        num_s4;
	logic                     neg_s4;

	logic                     d3_vld;
	logic [DIV_NW-1:0]        d3_q;
	logic                     d3_neg;
	side_t                    d3_side;

	logic signed [15:0]       res;
	logic                     sat;
	logic                     op_ok;
	logic                     vld_s5;
	logic signed [15:0]       sample_s5;
	logic                     sat_s5;

	assign cfg_ready = 1'b1;
	assign en        = !(vld_s5 && out_stall);
	assign in_stall  = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			per_q <= PERIOD_RST;
			mfs_q <= MFS_RST;
			sfs_q <= SFS_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_PERIOD: per_q <= cfg_data;
				CFG_MFS:    mfs_q <= cfg_data[MFS_W-1:0];
				CFG_SFS:    sfs_q <= cfg_data;
				default:    per_q <= per_q;
			endcase
		end
	end

	pwg_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (in_valid),
		.op      (operation),
		.ph      (phase),
		.mag     (magnitude),
		.per     (per_q),
		.mfs     (mfs_q),
		.out_vld (fr_vld),
		.num     (fr_num),
		.neg     (fr_neg),
		.side    (fr_side)
	);

	pwg_div u_div_per (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (fr_vld),
		.num      (fr_num),
		.neg_in   (fr_neg),
		.den      (per_q),
		.side_in  (fr_side),
		.out_vld  (d1_vld),
		.quot     (d1_q),
		.neg_out  (d1_neg),
		.side_out (d1_side)
	);

	assign half_p1 = {2'b0, per_q[PER_W-1:1]} + (PER_W+1)'(1);
	assign q1s     = d1_neg ? -$signed({2'b0, d1_q}) : $signed({2'b0, d1_q});
	assign mfs_w   = $signed(WAVE_W'(mfs_q));

	always_comb begin
		wave_c = '0;
		case (d1_side.op)
			OP_SQUARE: wave_c = ({1'b0, d1_side.ph} < half_p1) ? mfs_w : -mfs_w;
			OP_TRI:    wave_c = q1s - mfs_w;
			OP_SAW_UP: wave_c = q1s - mfs_w;
			OP_SAW_DN: wave_c = mfs_w - q1s;
			default:   wave_c = '0;
		endcase
	end

	always_comb begin
		side_c1      = d1_side;
		side_c1.wave = wave_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= d1_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= side_c1;
			ang_s1  <= d1_q[ANG_W-1:0];
		end
	end

	pwg_sine u_sine (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s1),
		.ang      (ang_s1),
		.side_in  (side_s1),
		.mfs      (mfs_q),
		.out_vld  (sn_vld),
		.num      (sn_num),
		.neg      (sn_neg),
		.side_out (sn_side)
	);

	pwg_div u_div_sfs (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (sn_vld),
		.num      (sn_num),
		.neg_in   (sn_neg),
		.den      (sfs_q),
		.side_in  (sn_side),
		.out_vld  (d2_vld),
		.quot     (d2_q),
		.neg_out  (d2_neg),
		.side_out (d2_side)
	);

	assign q2s  = d2_neg ? -$signed({2'b0, d2_q}) : $signed({2'b0, d2_q});
	assign pabs = p_s3[51] ? 51'(-p_s3) : 51'(p_s3);

	always_comb begin
		side_c2      = d2_side;
		side_c2.wave = (d2_side.op == OP_SINE) ? q2s : d2_side.wave;
	end

	always_comb begin
		side_c4     = side_s3;
		side_c4.big = pabs >= {19'b0, mfs_q, 17'b0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s2 <= d2_vld;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s2 <= side_c2;
			side_s3 <= side_s2;
			p_s3    <= 52'(side_s2.mag) * 52'(side_s2.wave);
			side_s4 <= side_c4;
			num_s4  <= pabs[DIV_NW-1:0];
			neg_s4  <= p_s3[51];
		end
	end

	pwg_div u_div_mfs (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s4),
		.num      (num_s4),
		.neg_in   (neg_s4),
		.den      ({1'b0, mfs_q}),
		.side_in  (side_s4),
		.out_vld  (d3_vld),
		.quot     (d3_q),
		.neg_out  (d3_neg),
		.side_out (d3_side)
	);

	assign op_ok = (d3_side.op == OP_SINE) || (d3_side.op == OP_SQUARE)
		|| (d3_side.op == OP_TRI) || (d3_side.op == OP_SAW_UP)
		|| (d3_side.op == OP_SAW_DN);

	always_comb begin
		res = '0;
		sat = 1'b0;
		if (op_ok && (mfs_q != '0)) begin
			if (d3_side.big) begin
				sat = 1'b1;
				res = d3_neg ? 16'sh8000 : 16'sh7fff;
			end else if (!d3_neg) begin
				if (d3_q > DIV_NW'(32767)) begin
					sat = 1'b1;
					res = 16'sh7fff;
				end else begin
					res = $signed(d3_q[15:0]);
				end
			end else begin
				if (d3_q > DIV_NW'(32768)) begin
					sat = 1'b1;
					res = 16'sh8000;
				end else begin
					res = $signed(16'(16'd0 - d3_q[15:0]));
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s5 <= d3_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sample_s5 <= res;
			sat_s5    <= sat;
		end
	end

	assign out_valid = vld_s5;
	assign sample    = sample_s5;
	assign saturated = sat_s5;

`ifndef SYNTHESIS
	a_sat_at_rail: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && saturated) |-> (sample == 16'sh7fff || sample == 16'sh8000))
		else $error("saturated result is not at a rail");

	a_zero_scale: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && mfs_q == '0) |-> (!saturated && sample == 16'sh0000))
		else $error("zero magnitude scale gave a nonzero result");

	a_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s5 && out_stall) |=> (vld_s5 && $stable(sample_s5) && $stable(sat_s5)))
		else $error("output stage changed while stalled");
`endif

endmodule
`default_nettype wire
